/* design/assert_macros.svh */
// assertion macros used by the checker file efe_checker.sv
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle while reset is held
`define EFE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, idle while reset is held
`define EFE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/efe_pkg.sv */
// types and constants of the escaped frame encoder
// no dependencies
package efe_pkg;

    localparam int unsigned SLOTS   = 4;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CNT_W   = 3;

    localparam logic [7:0] START_BYTE = 8'h7e;
    localparam logic [7:0] ESC_BYTE   = 8'h7d;
    localparam logic [7:0] XON_BYTE   = 8'h11;
    localparam logic [7:0] XOFF_BYTE  = 8'h13;
    localparam logic [7:0] ESC_FLIP   = 8'h20;
    localparam logic [7:0] SUM_BASE   = 8'hff;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    // the line bytes caused by one item
    typedef struct packed
    {
        logic [SLOTS-1:0][7:0] data_bytes;
        logic [SLOTS-1:0]      done;
        logic [CNT_W-1:0]      count;
    } efe_list_t;

    function automatic logic needs_escape(input logic [7:0] v);
        logic hit;
        begin
            hit = (v == START_BYTE) || (v == ESC_BYTE) || (v == XON_BYTE)
                || (v == XOFF_BYTE);
            return hit;
        end
    endfunction

endpackage

/* design/efe_encoder.sv */
// frame state and per-item encoding into a list of line bytes
// depends on efe_pkg
module efe_encoder
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              op,
    input  logic [7:0]        frame_length,
    input  logic [7:0]        payload_byte,
    output efe_pkg::efe_list_t list,
    output logic              has_results
);

    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic       frame_open_reg;
    logic       frame_open_next;

    logic [7:0] sum_add;
    logic [7:0] left_dec;
    logic [7:0] chk;
    logic       len_esc;
    logic       pb_esc;
    logic       chk_esc;

    always_comb
    begin
        sum_add  = running_sum_reg + payload_byte;
        left_dec = bytes_left_reg - 8'd1;
        chk      = efe_pkg::SUM_BASE - sum_add;
        len_esc  = efe_pkg::needs_escape(frame_length);
        pb_esc   = efe_pkg::needs_escape(payload_byte);
        chk_esc  = efe_pkg::needs_escape(chk);

        list             = '0;
        has_results      = 1'b0;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        frame_open_next  = frame_open_reg;

        if (op == efe_pkg::OP_START)
        begin
            has_results         = 1'b1;
            running_sum_next    = '0;
            bytes_left_next     = frame_length;
            frame_open_next     = (frame_length != 8'd0);
            list.data_bytes[0]  = efe_pkg::START_BYTE;
            if (len_esc)
            begin
                list.data_bytes[1] = efe_pkg::ESC_BYTE;
                list.data_bytes[2] = frame_length ^ efe_pkg::ESC_FLIP;
                list.count         = 3'd3;
            end
            else if (frame_length == 8'd0)
            begin
                // empty frame: checksum of nothing follows at once
                list.data_bytes[1] = frame_length;
                list.data_bytes[2] = efe_pkg::SUM_BASE;
                list.done[2]       = 1'b1;
                list.count         = 3'd3;
            end
            else
            begin
                list.data_bytes[1] = frame_length;
                list.count         = 3'd2;
            end
        end
        else if (frame_open_reg)
        begin
            has_results      = 1'b1;
            running_sum_next = sum_add;
            bytes_left_next  = left_dec;
            if (pb_esc)
            begin
                list.data_bytes[0] = efe_pkg::ESC_BYTE;
                list.data_bytes[1] = payload_byte ^ efe_pkg::ESC_FLIP;
                list.count         = 3'd2;
            end
            else
            begin
                list.data_bytes[0] = payload_byte;
                list.count         = 3'd1;
            end
            if (left_dec == 8'd0)
            begin
                frame_open_next = 1'b0;
                bytes_left_next = '0;
                if (chk_esc)
                begin
                    list.data_bytes[list.count[efe_pkg::IDX_W-1:0]]        =
                        efe_pkg::ESC_BYTE;
                    list.data_bytes[list.count[efe_pkg::IDX_W-1:0] + 2'd1] =
                        chk ^ efe_pkg::ESC_FLIP;
                    list.done[list.count[efe_pkg::IDX_W-1:0] + 2'd1]       = 1'b1;
                    list.count = list.count + 3'd2;
                end
                else
                begin
                    list.data_bytes[list.count[efe_pkg::IDX_W-1:0]] = chk;
                    list.done[list.count[efe_pkg::IDX_W-1:0]]       = 1'b1;
                    list.count = list.count + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= '0;
            running_sum_reg <= '0;
            frame_open_reg  <= 1'b0;
        end
        else if (accept)
        begin
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
            frame_open_reg  <= frame_open_next;
        end
    end

endmodule

/* design/efe_out_queue.sv */
// pending list register and output list register, one line byte per cycle while m_tready is high
// depends on efe_pkg
module efe_out_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_load,
    input  efe_pkg::efe_list_t in_list,
    output logic               in_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    efe_pkg::efe_list_t pend_reg;
    efe_pkg::efe_list_t out_reg;
    logic               pend_valid_reg;
    logic               out_valid_reg;
    logic [efe_pkg::IDX_W-1:0] idx_reg;

    logic is_last;
    logic out_done;
    logic move;

    always_comb
    begin
        is_last  = ({1'b0, idx_reg} == (out_reg.count - 3'd1));
        out_done = out_valid_reg && m_tready && is_last;
        move     = pend_valid_reg && (!out_valid_reg || out_done);
        in_ready = !pend_valid_reg || move;
        m_tvalid = out_valid_reg;
        m_tdata  = out_reg.data_bytes[idx_reg];
        m_tlast  = is_last;
        m_tuser  = out_reg.done[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (in_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (out_done)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (out_valid_reg && m_tready)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            pend_reg <= in_list;
        end
        if (move)
        begin
            out_reg <= pend_reg;
        end
    end

endmodule

/* design/escaped_frame_encoder.sv */
// top level of the escaped frame encoder
// depends on efe_pkg, efe_encoder and efe_out_queue
//
// channel  | dir | tdata                                       | tlast       | tuser
// s_axis   | in  | [7:0] frame_length, [15:8] payload_byte    | -           | op
// m_axis   | out | [7:0] line_byte                             | last_of_run | frame_done
//
// an item can be taken every cycle while the pending list register is free or moves on
// its list goes to the pending list register first, then to the output list register
// one to four line bytes follow, one per cycle while m_tready is high, from the output list register
// reset clears frame state and both list valid flags
// a stall on m_axis holds the bytes; s_tready falls while the pending register cannot move on
module escaped_frame_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // frame_length, payload_byte
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // line_byte
    output logic        m_tlast,
    output logic        m_tuser    // frame_done
);

    efe_pkg::efe_list_t list;
    logic               has_results;
    logic               accept;

    assign accept = s_tvalid && s_tready;

    efe_encoder u_encoder
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (s_tuser),
        .frame_length (s_tdata[7:0]),
        .payload_byte (s_tdata[15:8]),
        .list         (list),
        .has_results  (has_results)
    );

    efe_out_queue u_out_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_load  (accept && has_results),
        .in_list  (list),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* design/efe_checker.sv */
// port-level checks for the escaped frame encoder, bound to the top level
// depends on efe_pkg and assert_macros.svh
`include "assert_macros.svh"

module efe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    `EFE_ASSERT_NXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `EFE_ASSERT_IMP(a_done_is_last, m_tvalid && m_tuser, m_tlast)
    `EFE_ASSERT_IMP(a_start_never_ends, m_tvalid && m_tdata == efe_pkg::START_BYTE, !m_tlast && !m_tuser)
    `EFE_ASSERT_IMP(a_escape_never_ends, m_tvalid && m_tdata == efe_pkg::ESC_BYTE, !m_tlast && !m_tuser)

endmodule

bind escaped_frame_encoder efe_checker u_efe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* tb/tb_escaped_frame_encoder.sv */
`timescale 1ns / 1ps
// self-checking testbench for escaped_frame_encoder: directed table, then random frames
// under four idling phases, every line byte checked against a typed row or local encoder
// depends on efe_pkg and the escaped_frame_encoder rtl
module tb_escaped_frame_encoder;

    localparam int N_DIR      = 24;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 16;

    typedef struct packed
    {
        logic [7:0] line_byte;
        logic       last_of_run;
        logic       frame_done;
    } line_t;

    // typed rows list line bytes in order; last_of_run on the last, frame_done if ends_frame
    typedef struct packed
    {
        efe_pkg::op_t    op;
        logic [7:0]      frame_len;
        logic [7:0]      payload;
        logic            typed;
        logic [2:0]      n_lines;
        logic            ends_frame;
        logic [0:3][7:0] lines;
    } stim_row_t;

    stim_row_t dir_rows [0:N_DIR-1] = '{
        '{efe_pkg::OP_DATA,  8'h00, 8'h55, 1'b1, 3'd0, 1'b0, 32'h00000000}, // data with no frame
        '{efe_pkg::OP_START, 8'h00, 8'ha5, 1'b1, 3'd3, 1'b1, 32'h7e00ff00}, // zero-length frame
        '{efe_pkg::OP_DATA,  8'hff, 8'h00, 1'b1, 3'd0, 1'b0, 32'h00000000}, // data after it
        '{efe_pkg::OP_START, 8'h7e, 8'h00, 1'b1, 3'd3, 1'b0, 32'h7e7d5e00}, // escaped lengths
        '{efe_pkg::OP_START, 8'h7d, 8'hff, 1'b1, 3'd3, 1'b0, 32'h7e7d5d00},
        '{efe_pkg::OP_START, 8'h11, 8'h7e, 1'b1, 3'd3, 1'b0, 32'h7e7d3100},
        '{efe_pkg::OP_START, 8'h13, 8'h7d, 1'b1, 3'd3, 1'b0, 32'h7e7d3300},
        '{efe_pkg::OP_START, 8'hff, 8'h00, 1'b1, 3'd2, 1'b0, 32'h7eff0000},
        '{efe_pkg::OP_DATA,  8'h00, 8'h00, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'hff, 8'hff, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'h00, 8'h7e, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'h00, 8'h7d, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'h00, 8'h11, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'h00, 8'h13, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_START, 8'h02, 8'hff, 1'b0, 3'd0, 1'b0, 32'h0}, // restart drops open frame
        '{efe_pkg::OP_DATA,  8'h00, 8'h80, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'h00, 8'h7f, 1'b0, 3'd0, 1'b0, 32'h0}, // checksum zero
        '{efe_pkg::OP_START, 8'h01, 8'h00, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'h00, 8'h81, 1'b0, 3'd0, 1'b0, 32'h0}, // escaped checksum
        '{efe_pkg::OP_START, 8'h02, 8'h00, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'h00, 8'h70, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'h00, 8'h11, 1'b0, 3'd0, 1'b0, 32'h0}, // escaped byte and checksum
        '{efe_pkg::OP_START, 8'h01, 8'h00, 1'b0, 3'd0, 1'b0, 32'h0},
        '{efe_pkg::OP_DATA,  8'h00, 8'h00, 1'b0, 3'd0, 1'b0, 32'h0}  // checksum all ones
    };

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata  = 16'h0000;            // frame_length, payload_byte
    efe_pkg::op_t s_tuser  = efe_pkg::OP_START;   // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;                        // line_byte
    logic         m_tlast;
    logic         m_tuser;                        // frame_done

    stim_row_t   cur_row   = '0;
    logic        cur_typed = 1'b0;

    // encoder state kept by the testbench
    logic [7:0]  bytes_left;
    logic [7:0]  running_sum;
    logic        frame_open;

    line_t       encoded [$];
    line_t       line_expect [$];
    line_t       got;
    line_t       want;
    line_t       tail;

    int          fails          = 0;
    int          idle_cycles    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    escaped_frame_encoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    function automatic logic is_special(input logic [7:0] v);
        return (v == efe_pkg::START_BYTE) || (v == efe_pkg::ESC_BYTE)
            || (v == efe_pkg::XON_BYTE) || (v == efe_pkg::XOFF_BYTE);
    endfunction

    function automatic void emit_line(input logic [7:0] v, input logic done);
        encoded.push_back('{v, 1'b0, done});
    endfunction

    function automatic void emit_escaped(input logic [7:0] v, input logic done);
        if (is_special(v))
        begin
            emit_line(efe_pkg::ESC_BYTE, 1'b0);
            emit_line(v ^ efe_pkg::ESC_FLIP, done);
        end
        else
        begin
            emit_line(v, done);
        end
    endfunction

    function automatic void emit_checksum();
        frame_open = 1'b0;
        bytes_left = 8'h00;
        emit_escaped(efe_pkg::SUM_BASE - running_sum, 1'b1);
    endfunction

    // line bytes caused by one item, left in encoded
    function automatic void encode_item(input efe_pkg::op_t op, input logic [7:0] len,
                                        input logic [7:0] pb);
        encoded.delete();
        if (op == efe_pkg::OP_START)
        begin
            running_sum = 8'h00;
            bytes_left  = len;
            frame_open  = 1'b1;
            emit_line(efe_pkg::START_BYTE, 1'b0);
            emit_escaped(len, 1'b0);
            if (len == 8'h00)
                emit_checksum();
        end
        else if (frame_open)
        begin
            emit_escaped(pb, 1'b0);
            running_sum = running_sum + pb;
            bytes_left  = bytes_left - 8'h01;
            if (bytes_left == 8'h00)
                emit_checksum();
        end
        if (encoded.size() != 0)
        begin
            tail = encoded.pop_back();
            tail.last_of_run = 1'b1;
            encoded.push_back(tail);
        end
    endfunction

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata, m_tlast, m_tuser};
                if (line_expect.size() == 0)
                begin
                    $error("line byte %h with nothing expected", m_tdata);
                    fails++;
                end
                else
                begin
                    want = line_expect.pop_front();
                    if (got.line_byte !== want.line_byte)
                    begin
                        $error("line_byte: expected %h, got %h", want.line_byte, got.line_byte);
                        fails++;
                    end
                    if (got.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, got.last_of_run);
                        fails++;
                    end
                    if (got.frame_done !== want.frame_done)
                    begin
                        $error("frame_done: expected %b, got %b",
                               want.frame_done, got.frame_done);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                encode_item(s_tuser, s_tdata[7:0], s_tdata[15:8]);
                if (cur_typed)
                begin
                    for (int i = 0; i < cur_row.n_lines; i++)
                        line_expect.push_back('{cur_row.lines[i], i == cur_row.n_lines - 1,
                                                cur_row.ends_frame && i == cur_row.n_lines - 1});
                end
                else
                begin
                    foreach (encoded[i])
                        line_expect.push_back(encoded[i]);
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("escaped_frame_encoder regression: fail");
                $finish;
            end
        end
    end

    // entered and left at a falling edge
    task automatic drive_item(input efe_pkg::op_t op, input logic [7:0] len,
                              input logic [7:0] pb, input logic typed, input stim_row_t row);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= {pb, len};
        cur_typed <= typed;
        cur_row   <= row;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_payload();
        logic [7:0] specials [4];
        specials = '{efe_pkg::START_BYTE, efe_pkg::ESC_BYTE, efe_pkg::XON_BYTE,
                     efe_pkg::XOFF_BYTE};
        if ($urandom_range(0, 3) == 0)
            return specials[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly whole frames with random content, some cut short, some stray data
    task automatic random_frames(input int n_items);
        int         sent;
        int         n_data;
        int         sel;
        logic       was_open;
        logic [7:0] len;
        sent = 0;
        while (sent < n_items)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                was_open = frame_open;
                drive_item(efe_pkg::OP_DATA, 8'($urandom_range(0, 255)), pick_payload(),
                           1'b0, '0);
                if (was_open)
                    sent++;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    len = 8'($urandom_range(0, 6));
                else if (sel < 90)
                    len = 8'($urandom_range(7, 24));
                else
                    len = 8'($urandom_range(25, 255));
                n_data = len;
                if (len > 24)
                    n_data = $urandom_range(0, 12);
                else if (len != 0 && $urandom_range(0, 99) < 15)
                    n_data = $urandom_range(0, len - 1);
                drive_item(efe_pkg::OP_START, len, 8'($urandom_range(0, 255)), 1'b0, '0);
                sent++;
                for (int k = 0; k < n_data; k++)
                begin
                    drive_item(efe_pkg::OP_DATA, 8'($urandom_range(0, 255)), pick_payload(),
                               1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    task automatic drain_lines();
        while (line_expect.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 61, 0, 12};
        recv_pct = '{0, 0, 61, 12};
        bytes_left  = 8'h00;
        running_sum = 8'h00;
        frame_open  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            drive_item(dir_rows[i].op, dir_rows[i].frame_len, dir_rows[i].payload,
                       dir_rows[i].typed, dir_rows[i]);
        s_tvalid <= 1'b0;
        drain_lines();

        for (int p = 0; p < 4; p++)
        begin
            @(posedge clk);
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            @(negedge clk);
            random_frames(50);
            s_tvalid <= 1'b0;
            // sender holds off until every line byte is out
            drain_lines();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (fails == 0 && line_expect.size() == 0)
            $display("escaped_frame_encoder regression: pass");
        else
            $display("escaped_frame_encoder regression: fail");
        $finish;
    end

endmodule
